// ----- sv/yuv_to_rgb_downscaler_unit_defines.svh -----
// Assertion macros for the YUV to RGB downscaler.
// Included by the top level; no other dependencies.
`ifndef YUV_TO_RGB_DOWNSCALER_UNIT_DEFINES_SVH
`define YUV_TO_RGB_DOWNSCALER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define YRD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define YRD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`else

`define YRD_ASSERT(label, prop, msg)
`define YRD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- sv/yrd_pkg.sv -----
// Shared types, constants and helper functions of the YUV to RGB downscaler.
// No dependencies.
`default_nettype none

package yrd_pkg;

   localparam int MAX_SRC_DIM_DEFAULT = 8192;
   localparam int MAX_DST_DIM_DEFAULT = 4096;

   localparam int SRC_DIM_CFG_W = 14;
   localparam int DST_DIM_CFG_W = 13;
   localparam int STEP_W        = 30;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 30;
   localparam int PIX_W         = 8;
   localparam int PROD_W        = 28;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
   localparam logic [STEP_W-1:0] ACC_MAX    = {STEP_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;

   // BT.601 coefficients, 16.16 fixed point.
   localparam int K_FULL_RV = 91881;
   localparam int K_FULL_GU = 22554;
   localparam int K_FULL_GV = 46802;
   localparam int K_FULL_BU = 116130;
   localparam int K_LIM_Y   = 76284;
   localparam int K_LIM_RV  = 104595;
   localparam int K_LIM_GU  = 25624;
   localparam int K_LIM_GV  = 53281;
   localparam int K_LIM_BU  = 132251;
   localparam int CHROMA_OFFSET = 128;
   localparam int LUMA_OFFSET   = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_DST_WIDTH  = 3'd2,
      CSR_DST_HEIGHT = 3'd3,
      CSR_COL_STEP   = 3'd4,
      CSR_ROW_STEP   = 3'd5,
      CSR_FULL_RANGE = 3'd6
   } csr_index_type;

   // One selected source pixel on its way to conversion.
   typedef struct packed {
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] chroma_red;
      logic             row_end;
      logic             frame_end;
      logic             full_range;
   } pixel_type;

   function automatic logic [STEP_W-1:0] acc_add(input logic [STEP_W-1:0] a,
                                                 input logic [STEP_W-1:0] b);
      logic [STEP_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[STEP_W] ? ACC_MAX : sum[STEP_W-1:0];
   endfunction

   function automatic logic [PIX_W-1:0] sat8(input logic signed [PROD_W-1:0] v);
      logic [PIX_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > PROD_W'(255)) begin
         res = '1;
      end else begin
         res = v[PIX_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ----- sv/yrd_front.sv -----
// Front part: configuration registers, raster counters and 14.16 pick
// accumulators; decides which source items become output pixels. Uses yrd_pkg.
`default_nettype none

module yrd_front #(
   parameter int MAX_SRC_DIM = yrd_pkg::MAX_SRC_DIM_DEFAULT,
   parameter int MAX_DST_DIM = yrd_pkg::MAX_DST_DIM_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write,
   input  wire logic [yrd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [yrd_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                             accept,
   input  wire logic [yrd_pkg::PIX_W-1:0]        luma,
   input  wire logic [yrd_pkg::PIX_W-1:0]        chroma_blue,
   input  wire logic [yrd_pkg::PIX_W-1:0]        chroma_red,
   output logic                                  push,
   output yrd_pkg::pixel_type                    push_item
);

   localparam int SCW = $clog2(MAX_SRC_DIM);
   localparam int DCW = $clog2(MAX_DST_DIM) + 1;
   localparam int SW  = yrd_pkg::STEP_W;
   localparam int CW  = (SCW > 14) ? SCW : 14;

   logic [SCW-1:0] src_col_last_ff, src_col_last_in;
   logic [SCW-1:0] src_row_last_ff, src_row_last_in;
   logic [DCW-1:0] dst_width_ff, dst_width_in;
   logic [DCW-1:0] dst_height_ff, dst_height_in;
   logic [SW-1:0]  col_step_ff, col_step_in;
   logic [SW-1:0]  row_step_ff, row_step_in;
   logic           full_range_ff, full_range_in;

   logic [SCW-1:0] src_col_ff, src_col_in;
   logic [SCW-1:0] src_row_ff, src_row_in;
   logic [SW-1:0]  col_acc_ff, col_acc_in;
   logic [SW-1:0]  row_acc_ff, row_acc_in;
   logic [DCW-1:0] out_col_ff, out_col_in;
   logic [DCW-1:0] out_row_ff, out_row_in;

   logic row_sel, emit, row_done, frame_done;
   int   src_v, dst_v;

   // Registers hold effective sizes: zero source sizes and oversize are folded in here.
   always_comb begin
      src_col_last_in = src_col_last_ff;
      src_row_last_in = src_row_last_ff;
      dst_width_in    = dst_width_ff;
      dst_height_in   = dst_height_ff;
      col_step_in     = col_step_ff;
      row_step_in     = row_step_ff;
      full_range_in   = full_range_ff;
      src_v = int'(csr_data[yrd_pkg::SRC_DIM_CFG_W-1:0]);
      dst_v = int'(csr_data[yrd_pkg::DST_DIM_CFG_W-1:0]);
      if (src_v == 0) begin
         src_v = 1;
      end else if (src_v > MAX_SRC_DIM) begin
         src_v = MAX_SRC_DIM;
      end
      if (dst_v > MAX_DST_DIM) begin
         dst_v = MAX_DST_DIM;
      end
      if (csr_write) begin
         unique case (csr_index)
            yrd_pkg::CSR_SRC_WIDTH:  src_col_last_in = SCW'(src_v - 1);
            yrd_pkg::CSR_SRC_HEIGHT: src_row_last_in = SCW'(src_v - 1);
            yrd_pkg::CSR_DST_WIDTH:  dst_width_in    = DCW'(dst_v);
            yrd_pkg::CSR_DST_HEIGHT: dst_height_in   = DCW'(dst_v);
            yrd_pkg::CSR_COL_STEP:   col_step_in     = csr_data[SW-1:0];
            yrd_pkg::CSR_ROW_STEP:   row_step_in     = csr_data[SW-1:0];
            yrd_pkg::CSR_FULL_RANGE: full_range_in   = csr_data[0];
            default: ;
         endcase
      end
   end

   assign row_sel = (out_row_ff < dst_height_ff) &&
                    (CW'(row_acc_ff[SW-1:16]) <= CW'(src_row_ff));
   assign emit    = row_sel && (out_col_ff < dst_width_ff) &&
                    (CW'(col_acc_ff[SW-1:16]) <= CW'(src_col_ff));
   assign row_done   = src_col_ff >= src_col_last_ff;
   assign frame_done = src_row_ff >= src_row_last_ff;

   always_comb begin
      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      col_acc_in = col_acc_ff;
      row_acc_in = row_acc_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (emit) begin
            out_col_in = out_col_ff + DCW'(1);
            col_acc_in = yrd_pkg::acc_add(col_acc_ff, col_step_ff);
         end
         if (row_done) begin
            src_col_in = '0;
            col_acc_in = '0;
            out_col_in = '0;
            if (row_sel) begin
               out_row_in = out_row_ff + DCW'(1);
               row_acc_in = yrd_pkg::acc_add(row_acc_ff, row_step_ff);
            end
            if (frame_done) begin
               src_row_in = '0;
               row_acc_in = '0;
               out_row_in = '0;
            end else begin
               src_row_in = src_row_ff + SCW'(1);
            end
         end else begin
            src_col_in = src_col_ff + SCW'(1);
         end
      end
   end

   always_comb begin
      push                   = accept && emit;
      push_item.luma         = luma;
      push_item.chroma_blue  = chroma_blue;
      push_item.chroma_red   = chroma_red;
      push_item.row_end      = ({1'b0, out_col_ff} + (DCW+1)'(1)) == {1'b0, dst_width_ff};
      push_item.frame_end    = push_item.row_end &&
                               (({1'b0, out_row_ff} + (DCW+1)'(1)) == {1'b0, dst_height_ff});
      push_item.full_range   = full_range_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_col_last_ff <= '0;
         src_row_last_ff <= '0;
         dst_width_ff    <= DCW'(1);
         dst_height_ff   <= DCW'(1);
         col_step_ff     <= yrd_pkg::STEP_RESET;
         row_step_ff     <= yrd_pkg::STEP_RESET;
         full_range_ff   <= 1'b0;
         src_col_ff      <= '0;
         src_row_ff      <= '0;
         col_acc_ff      <= '0;
         row_acc_ff      <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
      end else begin
         src_col_last_ff <= src_col_last_in;
         src_row_last_ff <= src_row_last_in;
         dst_width_ff    <= dst_width_in;
         dst_height_ff   <= dst_height_in;
         col_step_ff     <= col_step_in;
         row_step_ff     <= row_step_in;
         full_range_ff   <= full_range_in;
         src_col_ff      <= src_col_in;
         src_row_ff      <= src_row_in;
         col_acc_ff      <= col_acc_in;
         row_acc_ff      <= row_acc_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/yrd_queue.sv -----
// Short first-in first-out queue of selected pixels between the front and
// the conversion back end. Uses yrd_pkg.
`default_nettype none

module yrd_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire yrd_pkg::pixel_type push_item,
   input  wire logic               pop,
   output logic                    not_empty,
   output logic                    full,
   output yrd_pkg::pixel_type      head_item
);

   localparam int DEPTH = yrd_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CNTW  = PW + 1;

   yrd_pkg::pixel_type entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign not_empty = count_ff != '0;
   assign full      = count_ff == CNTW'(DEPTH);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CNTW'(push) - CNTW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- sv/yrd_convert.sv -----
// Back part: two-stage BT.601 YCbCr to RGB conversion (products, then sums,
// floor and clamp) ending in the output register. Uses yrd_pkg.
`default_nettype none

module yrd_convert (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       item_valid,
   input  wire yrd_pkg::pixel_type         item,
   output logic                            pop,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [23:0]                     rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);

   localparam int PW = yrd_pkg::PROD_W;
   localparam int XW = yrd_pkg::PIX_W;

   logic signed [8:0]    uu, vv, yy;
   logic signed [PW-1:0] k_rv, k_gu, k_gv, k_bu, k_y;
   logic signed [PW-1:0] p_rv_ff, p_gu_ff, p_gv_ff, p_bu_ff, p_c_ff;
   logic [XW-1:0]        luma_ff;
   logic                 full_ff, row_end_ff, frame_end_ff;
   logic                 s1_valid_ff, s1_valid_in;

   logic                 out_valid_ff, out_valid_in;
   logic [XW-1:0]        red_ff, green_ff, blue_ff;
   logic                 last_ff, user_ff;

   logic                 advance;
   logic signed [PW-1:0] y_w, r_w, g_w, b_w;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = item_valid && (!s1_valid_ff || advance);

   always_comb begin
      uu = $signed({1'b0, item.chroma_blue}) - 9'(yrd_pkg::CHROMA_OFFSET);
      vv = $signed({1'b0, item.chroma_red})  - 9'(yrd_pkg::CHROMA_OFFSET);
      yy = $signed({1'b0, item.luma})        - 9'(yrd_pkg::LUMA_OFFSET);
      k_y  = PW'(yrd_pkg::K_LIM_Y);
      k_rv = item.full_range ? PW'(yrd_pkg::K_FULL_RV) : PW'(yrd_pkg::K_LIM_RV);
      k_gu = item.full_range ? PW'(yrd_pkg::K_FULL_GU) : PW'(yrd_pkg::K_LIM_GU);
      k_gv = item.full_range ? PW'(yrd_pkg::K_FULL_GV) : PW'(yrd_pkg::K_LIM_GV);
      k_bu = item.full_range ? PW'(yrd_pkg::K_FULL_BU) : PW'(yrd_pkg::K_LIM_BU);
   end

   // Stage one: the products.
   always_ff @(posedge clock) begin
      if (pop) begin
         p_rv_ff      <= k_rv * PW'(vv);
         p_gu_ff      <= k_gu * PW'(uu);
         p_gv_ff      <= k_gv * PW'(vv);
         p_bu_ff      <= k_bu * PW'(uu);
         p_c_ff       <= k_y * PW'(yy);
         luma_ff      <= item.luma;
         full_ff      <= item.full_range;
         row_end_ff   <= item.row_end;
         frame_end_ff <= item.frame_end;
      end
   end

   // Stage two: an arithmetic right shift by 16 floors the signed 12.16 value.
   // In full range luma is added after the shift; green subtracts a floored sum.
   always_comb begin
      y_w = $signed({{(PW-XW){1'b0}}, luma_ff});
      if (full_ff) begin
         r_w = y_w + (p_rv_ff >>> 16);
         g_w = y_w - ((p_gu_ff + p_gv_ff) >>> 16);
         b_w = y_w + (p_bu_ff >>> 16);
      end else begin
         r_w = (p_c_ff + p_rv_ff) >>> 16;
         g_w = (p_c_ff - p_gu_ff - p_gv_ff) >>> 16;
         b_w = (p_c_ff + p_bu_ff) >>> 16;
      end
   end

   always_comb begin
      s1_valid_in  = pop ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         red_ff   <= yrd_pkg::sat8(r_w);
         green_ff <= yrd_pkg::sat8(g_w);
         blue_ff  <= yrd_pkg::sat8(b_w);
         last_ff  <= row_end_ff;
         user_ff  <= frame_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {blue_ff, green_ff, red_ff};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

// ----- sv/yuv_to_rgb_downscaler_unit.sv -----
// Top level of the YUV to RGB downscaler: front, queue and conversion back end.
// Depends on yrd_pkg, yrd_front, yrd_queue, yrd_convert and the defines header.
//
// Source pixels enter in raster order, one item per clock while the four-entry
// queue has room; the queue only fills when the output side stalls. Each one
// that is the nearest-neighbour pick for the next destination pixel leaves as
// one RGB24 item through the queue, the product stage and the output register.
// Register writes take effect at once and are meant to happen between frames
// while no item is in flight.
`default_nettype none

`include "yuv_to_rgb_downscaler_unit_defines.svh"

module yuv_to_rgb_downscaler_unit #(
   parameter int MAX_SRC_DIM = yrd_pkg::MAX_SRC_DIM_DEFAULT,
   parameter int MAX_DST_DIM = yrd_pkg::MAX_DST_DIM_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [yrd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [yrd_pkg::CSR_DATA_W-1:0]  csr_data,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // [7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
   input  wire logic [23:0]                     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue
   output logic [23:0]                          rsp_tdata,
   // row_end
   output logic                                 rsp_tlast,
   // [0] frame_end
   output logic                                 rsp_tuser
);

   logic               accept;
   logic               push, pop, q_not_empty, q_full;
   yrd_pkg::pixel_type push_item, head_item;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   yrd_front #(
      .MAX_SRC_DIM (MAX_SRC_DIM),
      .MAX_DST_DIM (MAX_DST_DIM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .accept      (accept),
      .luma        (req_tdata[7:0]),
      .chroma_blue (req_tdata[15:8]),
      .chroma_red  (req_tdata[23:16]),
      .push        (push),
      .push_item   (push_item)
   );

   yrd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head_item (head_item)
   );

   yrd_convert u_convert (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The last pixel of a frame is always the last pixel of its row.
   `YRD_ASSERT(a_frame_end_on_row_end, rsp_tvalid && rsp_tuser |-> rsp_tlast, "frame end without row end")
   // A full queue can only come from a stalled output register.
   `YRD_ASSERT(a_full_means_stalled, !req_tready |-> rsp_tvalid, "queue full while output idle")
   // Nothing is left in flight after reset.
   `YRD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_tvalid && req_tready, "state not cleared by reset")

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for yuv_to_rgb_downscaler_unit: YUV pixel stream in,
// predicted RGB24 picks compared against the response stream item by item.
// Depends on yrd_pkg and the RTL of the unit; needs no files at run time.

module tb_top;

   localparam int          STALL_LIMIT   = 1000;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          SRC_LIMIT     = yrd_pkg::MAX_SRC_DIM_DEFAULT;
   localparam int          DST_LIMIT     = yrd_pkg::MAX_DST_DIM_DEFAULT;
   localparam logic [29:0] ACC_TOP       = 30'h3FFF_FFFF;
   localparam int          UNITY_STEP    = 65536;

   // BT.601 coefficients in 16.16, full range and limited range.
   localparam int FR_RV = 91881;
   localparam int FR_GU = 22554;
   localparam int FR_GV = 46802;
   localparam int FR_BU = 116130;
   localparam int LR_Y  = 76284;
   localparam int LR_RV = 104595;
   localparam int LR_GU = 25624;
   localparam int LR_GV = 53281;
   localparam int LR_BU = 132251;
   localparam int UV_BIAS = 128;
   localparam int Y_BIAS  = 16;

   typedef struct packed {
      logic [7:0] chroma_red;
      logic [7:0] chroma_blue;
      logic [7:0] luma;
   } yuv_pixel_type;

   typedef struct packed {
      logic       frame_end;
      logic       row_end;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   yrd_pkg::csr_index_type csr_index = yrd_pkg::CSR_SRC_WIDTH;
   logic [29:0]            csr_data = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   // Register copies and raster position of the predictor.
   logic [13:0] cfg_src_w = 14'd1;
   logic [13:0] cfg_src_h = 14'd1;
   logic [12:0] cfg_dst_w = 13'd1;
   logic [12:0] cfg_dst_h = 13'd1;
   logic [29:0] cfg_col_step = 30'(UNITY_STEP);
   logic [29:0] cfg_row_step = 30'(UNITY_STEP);
   logic        cfg_full = 1'b0;
   logic [12:0] src_col = '0;
   logic [12:0] src_row = '0;
   logic [12:0] out_col = '0;
   logic [12:0] out_row = '0;
   logic [29:0] col_acc = '0;
   logic [29:0] row_acc = '0;

   yuv_pixel_type yuv_backlog[$];
   rgb_pixel_type rgb_due[$];
   int            error_count = 0;
   int            stall_cycles = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;

   yuv_to_rgb_downscaler_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int src_extent(logic [13:0] v);
      if (v == 0) begin
         return 1;
      end
      return (v > SRC_LIMIT) ? SRC_LIMIT : int'(v);
   endfunction

   function automatic int dst_extent(logic [12:0] v);
      return (v > DST_LIMIT) ? DST_LIMIT : int'(v);
   endfunction

   function automatic logic [29:0] step_add(logic [29:0] a, logic [29:0] b);
      logic [30:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, ACC_TOP}) ? ACC_TOP : s[29:0];
   endfunction

   function automatic logic [7:0] clamp_byte(int v);
      if (v < 0) begin
         return 8'd0;
      end
      return (v > 255) ? 8'd255 : 8'(v);
   endfunction

   function automatic rgb_pixel_type yuv_to_rgb(yuv_pixel_type px, logic full);
      rgb_pixel_type res;
      int            y;
      int            u;
      int            v;
      int            c;
      y = int'(px.luma);
      u = int'(px.chroma_blue);
      v = int'(px.chroma_red);
      u = u - UV_BIAS;
      v = v - UV_BIAS;
      res = '0;
      // An arithmetic shift of a signed int is floor division by 65536.
      if (full) begin
         res.red   = clamp_byte(y + ((FR_RV * v) >>> 16));
         res.green = clamp_byte(y - ((FR_GU * u + FR_GV * v) >>> 16));
         res.blue  = clamp_byte(y + ((FR_BU * u) >>> 16));
      end else begin
         c = LR_Y * (y - Y_BIAS);
         res.red   = clamp_byte((c + LR_RV * v) >>> 16);
         res.green = clamp_byte((c - LR_GU * u - LR_GV * v) >>> 16);
         res.blue  = clamp_byte((c + LR_BU * u) >>> 16);
      end
      return res;
   endfunction

   // Advances the raster position by one source pixel and queues the RGB
   // item that it yields, if it is the pick for the next output pixel.
   function automatic void advance_raster(yuv_pixel_type px);
      int            sw;
      int            sh;
      int            dw;
      int            dh;
      logic          row_pick;
      rgb_pixel_type rgb;
      sw = src_extent(cfg_src_w);
      sh = src_extent(cfg_src_h);
      dw = dst_extent(cfg_dst_w);
      dh = dst_extent(cfg_dst_h);
      row_pick = (out_row < dh) && ((row_acc >> 16) <= src_row);
      if (row_pick && out_col < dw && (col_acc >> 16) <= src_col) begin
         rgb = yuv_to_rgb(px, cfg_full);
         rgb.row_end = (out_col == dw - 1);
         rgb.frame_end = rgb.row_end && (out_row == dh - 1);
         rgb_due.push_back(rgb);
         out_col = out_col + 13'd1;
         col_acc = step_add(col_acc, cfg_col_step);
      end
      if (src_col >= sw - 1) begin
         src_col = '0;
         col_acc = '0;
         out_col = '0;
         if (row_pick) begin
            out_row = out_row + 13'd1;
            row_acc = step_add(row_acc, cfg_row_step);
         end
         if (src_row >= sh - 1) begin
            src_row = '0;
            row_acc = '0;
            out_row = '0;
         end else begin
            src_row = src_row + 13'd1;
         end
      end else begin
         src_col = src_col + 13'd1;
      end
   endfunction

   function automatic void apply_reg(yrd_pkg::csr_index_type idx, logic [29:0] val);
      case (idx)
         yrd_pkg::CSR_SRC_WIDTH:  cfg_src_w = val[13:0];
         yrd_pkg::CSR_SRC_HEIGHT: cfg_src_h = val[13:0];
         yrd_pkg::CSR_DST_WIDTH:  cfg_dst_w = val[12:0];
         yrd_pkg::CSR_DST_HEIGHT: cfg_dst_h = val[12:0];
         yrd_pkg::CSR_COL_STEP:   cfg_col_step = val;
         yrd_pkg::CSR_ROW_STEP:   cfg_row_step = val;
         yrd_pkg::CSR_FULL_RANGE: cfg_full = val[0];
         default: ;
      endcase
   endfunction

   // Writes all seven registers back to back, holding csr_valid high.
   task automatic program_regs(int sw, int sh, int dw, int dh, int cs, int rs, logic fr);
      logic [29:0]            vals[7];
      yrd_pkg::csr_index_type order[7];
      vals = '{30'(sw), 30'(sh), 30'(dw), 30'(dh), 30'(cs), 30'(rs), {29'd0, fr}};
      order = '{yrd_pkg::CSR_SRC_WIDTH, yrd_pkg::CSR_SRC_HEIGHT, yrd_pkg::CSR_DST_WIDTH,
                yrd_pkg::CSR_DST_HEIGHT, yrd_pkg::CSR_COL_STEP, yrd_pkg::CSR_ROW_STEP,
                yrd_pkg::CSR_FULL_RANGE};
      @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         apply_reg(order[i], vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_sample();
      int pick;
      pick = int'($urandom_range(7));
      if (pick == 0) begin
         return 8'd0;
      end
      return (pick == 1) ? 8'd255 : 8'($urandom_range(255));
   endfunction

   task automatic queue_random_pixels(int n);
      yuv_pixel_type px;
      for (int i = 0; i < n; i++) begin
         px.luma = random_sample();
         px.chroma_blue = random_sample();
         px.chroma_red = random_sample();
         yuv_backlog.push_back(px);
      end
   endtask

   // Waits until every pixel is sent and every expected item has come back.
   task automatic wait_drained();
      do @(negedge clock);
      while (yuv_backlog.size() != 0 || req_tvalid || rgb_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_case(int sw, int sh, int dw, int dh, int cs, int rs, logic fr,
                           int n);
      program_regs(sw, sh, dw, dh, cs, rs, fr);
      @(negedge clock);
      queue_random_pixels(n);
      wait_drained();
   endtask

   always @(posedge clock) begin : yuv_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            advance_raster(req_tdata);
         end
         if (!req_tvalid || req_tready) begin
            if (yuv_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= yuv_backlog.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rgb_monitor
      rgb_pixel_type got;
      rgb_pixel_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tlast, rsp_tdata};
            if (rgb_due.size() == 0) begin
               error_count++;
               $display("%0t: expected no pixel, got r=%0d g=%0d b=%0d %0b/%0b",
                        $time, got.red, got.green, got.blue, got.row_end,
                        got.frame_end);
            end else begin
               want = rgb_due.pop_front();
               if (got.red != want.red || got.green != want.green ||
                   got.blue != want.blue || got.row_end != want.row_end ||
                   got.frame_end != want.frame_end) begin
                  error_count++;
                  $display("%0t: expected r=%0d g=%0d b=%0d %0b/%0b, got %s",
                           $time, want.red, want.green, want.blue, want.row_end,
                           want.frame_end,
                           $sformatf("r=%0d g=%0d b=%0d %0b/%0b (row_end/frame_end)",
                                     got.red, got.green, got.blue, got.row_end,
                                     got.frame_end));
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      yuv_pixel_type corners[10];
      int            sw;
      int            sh;
      int            dw;
      int            dh;
      int            sw_eff;
      int            sh_eff;
      int            n;
      int            variant;
      int            random_items;
      int            phase;
      int            cs;
      int            rs;
      logic          fr;

      corners = '{
         '{luma: 8'd0,   chroma_blue: 8'd0,   chroma_red: 8'd0},
         '{luma: 8'd255, chroma_blue: 8'd255, chroma_red: 8'd255},
         '{luma: 8'd0,   chroma_blue: 8'd255, chroma_red: 8'd255},
         '{luma: 8'd255, chroma_blue: 8'd0,   chroma_red: 8'd0},
         '{luma: 8'd16,  chroma_blue: 8'd128, chroma_red: 8'd128},
         '{luma: 8'd235, chroma_blue: 8'd128, chroma_red: 8'd128},
         '{luma: 8'd255, chroma_blue: 8'd128, chroma_red: 8'd128},
         '{luma: 8'd0,   chroma_blue: 8'd128, chroma_red: 8'd128},
         '{luma: 8'd128, chroma_blue: 8'd0,   chroma_red: 8'd255},
         '{luma: 8'd128, chroma_blue: 8'd255, chroma_red: 8'd0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Extreme samples through the reset setting (1x1, limited range), then
      // through a 1x1 full-range setting; every item is its own frame.
      send_idle_pct = 18;
      recv_stall_pct = 18;
      @(negedge clock);
      foreach (corners[i]) yuv_backlog.push_back(corners[i]);
      wait_drained();
      program_regs(1, 1, 1, 1, UNITY_STEP, UNITY_STEP, 1'b1);
      @(negedge clock);
      foreach (corners[i]) yuv_backlog.push_back(corners[i]);
      wait_drained();

      // Zero output width: nothing comes out.
      run_case(3, 2, 0, 2, UNITY_STEP, UNITY_STEP, 1'b0, 6);
      // Half-pixel step: every source pixel of the row is picked.
      run_case(3, 1, 3, 1, UNITY_STEP / 2, UNITY_STEP, 1'b0, 3);
      // Saturating steps: only the first pixel of the frame is picked.
      run_case(4, 2, 3, 2, int'(ACC_TOP), int'(ACC_TOP), 1'b1, 8);
      // Zero source size acts as a single pixel.
      run_case(0, 0, 1, 1, UNITY_STEP, UNITY_STEP, 1'b0, 2);
      // Shrink the width mid-frame while the position is past the new last column.
      run_case(6, 2, 3, 2, 2 * UNITY_STEP, UNITY_STEP, 1'b0, 4);
      run_case(3, 2, 3, 2, UNITY_STEP, UNITY_STEP, 1'b1, 6);

      // Oversized source dimensions clamp to the maximum; the frame wraps after
      // the clamped size and the next frame starts picking again.
      send_idle_pct = 0;
      recv_stall_pct = 0;
      run_case('h3FFF, 1, 4, 1, 2730 * UNITY_STEP, UNITY_STEP, 1'b0, SRC_LIMIT + 2);
      run_case(1, 'h3FFF, 1, 2, UNITY_STEP, 8191 * UNITY_STEP, 1'b1, SRC_LIMIT + 1);

      random_items = 0;
      phase = 0;
      while (random_items < 1400) begin
         case ((phase / 2) % 4)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 52;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 52;
            end
            default: begin
               send_idle_pct = 18;
               recv_stall_pct = 18;
            end
         endcase
         variant = int'($urandom_range(11));
         sw = int'($urandom_range(1, 20));
         sh = int'($urandom_range(1, 10));
         if (variant == 5) begin
            sw = 0;
         end else if (variant == 6) begin
            sh = 0;
         end
         sw_eff = (sw == 0) ? 1 : sw;
         sh_eff = (sh == 0) ? 1 : sh;
         dw = int'($urandom_range(1, sw_eff));
         dh = int'($urandom_range(1, sh_eff));
         cs = (sw_eff * UNITY_STEP) / dw;
         rs = (sh_eff * UNITY_STEP) / dh;
         case (variant)
            0: begin
               cs = int'($urandom_range(0, UNITY_STEP - 1));
               dw = int'($urandom_range(1, 2 * sw_eff));
            end
            1: begin
               rs = int'($urandom_range(0, UNITY_STEP - 1));
               dh = int'($urandom_range(1, 2 * sh_eff));
            end
            2: begin
               cs = int'($urandom_range(UNITY_STEP, int'(ACC_TOP)));
               rs = int'($urandom_range(UNITY_STEP, int'(ACC_TOP)));
            end
            3: dw = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(DST_LIMIT + 1, 8191));
            4: dh = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(DST_LIMIT + 1, 8191));
            default: ;
         endcase
         fr = 1'($urandom_range(1));
         // Mostly whole frames; now and then a broken one, so that the next
         // register set lands in the middle of a frame.
         if ($urandom_range(4) == 0) begin
            n = int'($urandom_range(1, sw_eff * sh_eff));
         end else begin
            n = sw_eff * sh_eff * int'($urandom_range(1, 2));
         end
         run_case(sw, sh, dw, dh, cs, rs, fr, n);
         random_items += n;
         phase++;
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ----- yuv_to_rgb_downscaler_unit.f -----
+incdir+sv
sv/yrd_pkg.sv
sv/yrd_front.sv
sv/yrd_queue.sv
sv/yrd_convert.sv
sv/yuv_to_rgb_downscaler_unit.sv
dv/tb_top.sv
